// ===== hdl/amq_pkg.sv =====
package amq_pkg;

   localparam int QueueDepth = 32;
   localparam int PrioWidth  = 16;
   localparam int WaitWidth  = 3;
   localparam int BonusWidth = 8;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   localparam logic [WaitWidth-1:0]  ThresholdReset = 3'd5;
   localparam logic [BonusWidth-1:0] BonusReset     = 8'd2;
   localparam logic [PrioWidth-1:0]  PrioMax        = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_ADDED    = 3'd0,
      STAT_IGNORED  = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_RETURNED = 3'd3,
      STAT_EMPTY    = 3'd4,
      STAT_CLEARED  = 3'd5
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_AGE_THRESHOLD = 2'd0,
      CSR_AGE_BONUS     = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_APPLY
   } state_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [PrioWidth-1:0] new_priority;
   } req_word_type;

   typedef struct packed {
      logic [PrioWidth-1:0] job_priority;
      logic [2:0]           status;
   } rsp_word_type;

   typedef struct packed {
      logic                  valid;
      logic [PrioWidth-1:0]  prio;
   } cand_type;

   typedef struct packed {
      logic                  load;
      logic                  shift_age;
      logic [PrioWidth-1:0]  new_prio;
      logic [WaitWidth-1:0]  threshold;
      logic [BonusWidth-1:0] bonus;
   } cell_ctrl_type;

endpackage

// ===== hdl/aging_max_priority_queue.sv =====
// Aging max-priority job queue built as a row of slot cells.
// Input channel req_: a word carries a command (add, get, clear) and the
// priority of a job to add. A word is taken when req_valid is high and
// req_stall is low. Every command yields exactly one word on rsp_, carrying
// the removed job's priority and a status code.
// Add, clear and a get on an empty queue answer in the cycle after the word
// is taken, so such words can follow one per cycle while rsp_stall is low. A
// get on a nonempty queue scans first: the best candidate ripples through the
// chain of cells one cell per cycle, then the apply state removes the job,
// shifts the younger jobs down and ages the rest.
// One command is in flight at a time; req_stall stays high until the block
// is back in idle and its output register is free or being emptied.
// rsp_valid holds and the response word stays put while rsp_stall is high.
// csr_ writes set age_threshold (index 0) and age_bonus (index 1); csr_ready
// is always high, and writes are meant for an idle block.
// Synchronous reset empties the queue, drops any pending response and
// restores threshold 5 and bonus 2. Slot contents are not cleared.
module aging_max_priority_queue #(
   parameter int QUEUE_DEPTH = amq_pkg::QueueDepth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  amq_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output amq_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [amq_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [amq_pkg::CsrDataWidth-1:0]     csr_data
);
   import amq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH+1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic [WaitWidth-1:0]  threshold_ff;
   logic [BonusWidth-1:0] bonus_ff;

   cell_ctrl_type         ctrl;
   logic                  req_take;
   logic [IW-1:0]         best_idx;

   logic [PrioWidth-1:0]  slot_prio [QUEUE_DEPTH];
   logic [WaitWidth-1:0]  slot_wait [QUEUE_DEPTH];
   cand_type              cand      [QUEUE_DEPTH+1];
   logic [IW-1:0]         cand_idx  [QUEUE_DEPTH+1];

   assign cand[0]     = '0;
   assign cand_idx[0] = '0;
   assign best_idx    = cand_idx[QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [PrioWidth-1:0] up_prio;
      logic [WaitWidth-1:0] up_wait;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign up_prio = slot_prio[i];
         assign up_wait = slot_wait[i];
      end else begin : g_mid
         assign up_prio = slot_prio[i+1];
         assign up_wait = slot_wait[i+1];
      end
      amq_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .count        (count_ff),
         .best_idx     (best_idx),
         .next_prio    (up_prio),
         .next_wait    (up_wait),
         .cand_in      (cand[i]),
         .cand_idx_in  (cand_idx[i]),
         .prio         (slot_prio[i]),
         .wait_cnt     (slot_wait[i]),
         .cand_out     (cand[i+1]),
         .cand_idx_out (cand_idx[i+1])
      );
   end

   assign req_stall = (state_ff != STATE_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_cnt_in  = scan_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      ctrl.load      = 1'b0;
      ctrl.shift_age = 1'b0;
      ctrl.new_prio  = req_word.new_priority;
      ctrl.threshold = threshold_ff;
      ctrl.bonus     = bonus_ff;

      case (state_ff)
         STATE_IDLE: begin
            if (req_take) begin
               rsp_word_in.job_priority = '0;
               rsp_valid_in             = 1'b1;
               case (req_word.command)
                  CMD_ADD: begin
                     if (req_word.new_priority == '0) begin
                        rsp_word_in.status = STAT_IGNORED;
                     end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_word_in.status = STAT_FULL;
                     end else begin
                        ctrl.load          = 1'b1;
                        count_in           = count_ff + 1'b1;
                        rsp_word_in.status = STAT_ADDED;
                     end
                  end
                  CMD_GET: begin
                     if (count_ff == '0) begin
                        rsp_word_in.status = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        scan_cnt_in  = '0;
                        state_in     = STATE_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in           = '0;
                     rsp_word_in.status = STAT_CLEARED;
                  end
                  default: begin
                     rsp_word_in.status = STAT_IGNORED;
                  end
               endcase
            end
         end
         STATE_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IW'(QUEUE_DEPTH - 1)) begin
               state_in = STATE_APPLY;
            end
         end
         STATE_APPLY: begin
            ctrl.shift_age           = 1'b1;
            count_in                 = count_ff - 1'b1;
            rsp_valid_in             = 1'b1;
            rsp_word_in.job_priority = cand[QUEUE_DEPTH].prio;
            rsp_word_in.status       = STAT_RETURNED;
            state_in                 = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      scan_cnt_ff <= scan_cnt_in;
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= ThresholdReset;
         bonus_ff     <= BonusReset;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AGE_THRESHOLD: threshold_ff <= csr_data[WaitWidth-1:0];
               CSR_AGE_BONUS:     bonus_ff     <= csr_data[BonusWidth-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hdl/amq_cell.sv =====
module amq_cell #(
   parameter int QUEUE_DEPTH = amq_pkg::QueueDepth,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  amq_pkg::cell_ctrl_type                ctrl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      count,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]        best_idx,
   input  logic [amq_pkg::PrioWidth-1:0]         next_prio,
   input  logic [amq_pkg::WaitWidth-1:0]         next_wait,
   input  amq_pkg::cand_type                     cand_in,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]        cand_idx_in,
   output logic [amq_pkg::PrioWidth-1:0]         prio,
   output logic [amq_pkg::WaitWidth-1:0]         wait_cnt,
   output amq_pkg::cand_type                     cand_out,
   output logic [$clog2(QUEUE_DEPTH)-1:0]        cand_idx_out
);
   import amq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH+1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [PrioWidth-1:0] prio_ff, prio_in;
   logic [WaitWidth-1:0] wait_ff, wait_in;
   cand_type             cand_ff, cand_in_next;
   logic [IW-1:0]        cand_idx_ff, cand_idx_in_next;

   logic                 occupied;
   logic                 take_own;
   logic [PrioWidth-1:0] base_prio;
   logic [WaitWidth-1:0] base_wait;
   logic [WaitWidth-1:0] wait_inc;
   logic [PrioWidth:0]   prio_sum;

   always_comb begin
      occupied = CW'(CELL_INDEX) < count;
      take_own = occupied && (!cand_in.valid || prio_ff > cand_in.prio);
      if (take_own) begin
         cand_in_next.valid = 1'b1;
         cand_in_next.prio  = prio_ff;
         cand_idx_in_next   = IW'(CELL_INDEX);
      end else begin
         cand_in_next     = cand_in;
         cand_idx_in_next = cand_idx_in;
      end

      // On a removal, cells at or above the removed slot take their upper
      // neighbor, and every job ages in the same cycle.
      if (IW'(CELL_INDEX) >= best_idx) begin
         base_prio = next_prio;
         base_wait = next_wait;
      end else begin
         base_prio = prio_ff;
         base_wait = wait_ff;
      end
      wait_inc = (base_wait < ctrl.threshold) ? base_wait + 1'b1 : base_wait;
      prio_sum = {1'b0, base_prio} + {{(PrioWidth+1-BonusWidth){1'b0}}, ctrl.bonus};

      prio_in = prio_ff;
      wait_in = wait_ff;
      if (ctrl.load && count == CW'(CELL_INDEX)) begin
         prio_in = ctrl.new_prio;
         wait_in = '0;
      end else if (ctrl.shift_age) begin
         wait_in = wait_inc;
         if (wait_inc >= ctrl.threshold) begin
            prio_in = prio_sum[PrioWidth] ? PrioMax : prio_sum[PrioWidth-1:0];
         end else begin
            prio_in = base_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff     <= prio_in;
      wait_ff     <= wait_in;
      cand_idx_ff <= cand_idx_in_next;
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in_next;
      end
   end

   assign prio         = prio_ff;
   assign wait_cnt     = wait_ff;
   assign cand_out     = cand_ff;
   assign cand_idx_out = cand_idx_ff;

endmodule

// ===== hdl/amq_checker.sv =====
module amq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input amq_pkg::req_word_type              req_word,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input amq_pkg::rsp_word_type              rsp_word
);
   import amq_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // Reset drops any pending response word.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   // Commands other than a get answer in the next cycle without a job.
   a_fast_answer: assert property (@(posedge clock) disable iff (reset)
      req_take && req_word.command != CMD_GET
      |=> rsp_valid && rsp_word.status != STAT_RETURNED)
      else $error("missing or wrong response to a non-get command");

   // A get answers at once only when the queue is empty.
   a_get_scan: assert property (@(posedge clock) disable iff (reset)
      req_take && req_word.command == CMD_GET
      |=> !rsp_valid || rsp_word.status == STAT_EMPTY)
      else $error("get answered before the scan finished");

   a_zero_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STAT_RETURNED |-> rsp_word.job_priority == '0)
      else $error("nonzero priority without a returned job");

endmodule

bind aging_max_priority_queue amq_checker u_amq_checker (.*);

// ===== tb/aging_max_priority_queue_tb.sv =====
module aging_max_priority_queue_tb;

   import amq_pkg::*;

   localparam logic [1:0] CmdUnused   = 2'd3;
   localparam int         NumDirected = 21;
   localparam int         HoldCycles  = 300;
   localparam int         IdleLimit   = 3000;
   localparam int         ReportLimit = 10;

   typedef struct packed {
      logic [1:0]           command;
      logic [PrioWidth-1:0] new_priority;
      logic                 fixed;
      rsp_word_type         rsp;
   } directed_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_word_type               req_word;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_word_type               rsp_word;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CsrIndexWidth-1:0]   csr_index;
   logic [CsrDataWidth-1:0]    csr_data;

   // Shadow copy of the queue: slot 0 holds the oldest job.
   logic [PrioWidth-1:0]  queued_prio [QueueDepth];
   logic [WaitWidth-1:0]  queued_wait [QueueDepth];
   int                    queued_total;
   logic [WaitWidth-1:0]  cfg_threshold;
   logic [BonusWidth-1:0] cfg_bonus;

   rsp_word_type pending_rsp[$];
   rsp_word_type oldest_rsp;
   int           mismatch_count;
   int           idle_cycles;
   int           send_idle_pct;
   int           rsp_stall_pct;
   logic         hold_off;
   event         hold_go;

   directed_row_type directed_rows [NumDirected] = '{
      '{CMD_GET,   16'h0000, 1'b1, '{16'h0000, STAT_EMPTY}},
      '{CMD_ADD,   16'h0000, 1'b1, '{16'h0000, STAT_IGNORED}},
      '{CmdUnused, 16'hFFFF, 1'b1, '{16'h0000, STAT_IGNORED}},
      '{CMD_CLEAR, 16'h0000, 1'b1, '{16'h0000, STAT_CLEARED}},
      '{CMD_ADD,   16'hFFFF, 1'b1, '{16'h0000, STAT_ADDED}},
      '{CMD_ADD,   16'h0001, 1'b1, '{16'h0000, STAT_ADDED}},
      '{CMD_ADD,   16'h8000, 1'b1, '{16'h0000, STAT_ADDED}},
      '{CMD_ADD,   16'hFFFF, 1'b1, '{16'h0000, STAT_ADDED}},
      '{CMD_ADD,   16'h7FFF, 1'b1, '{16'h0000, STAT_ADDED}},
      '{CMD_GET,   16'h0000, 1'b1, '{16'hFFFF, STAT_RETURNED}},
      '{CMD_GET,   16'hFFFF, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_GET,   16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_ADD,   16'hFFFE, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_GET,   16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_GET,   16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_GET,   16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_GET,   16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_ADD,   16'h1234, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CmdUnused, 16'h0000, 1'b0, '{16'h0000, STAT_EMPTY}},
      '{CMD_CLEAR, 16'hFFFF, 1'b1, '{16'h0000, STAT_CLEARED}},
      '{CMD_GET,   16'h0000, 1'b1, '{16'h0000, STAT_EMPTY}}
   };

   aging_max_priority_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   function automatic rsp_word_type predict_rsp(req_word_type w);
      rsp_word_type        r;
      int                  best;
      logic [PrioWidth:0]  sum;
      r.job_priority = '0;
      r.status = STAT_IGNORED;
      case (w.command)
         CMD_ADD: begin
            if (w.new_priority == '0) begin
               r.status = STAT_IGNORED;
            end else if (queued_total >= QueueDepth) begin
               r.status = STAT_FULL;
            end else begin
               queued_prio[queued_total] = w.new_priority;
               queued_wait[queued_total] = '0;
               queued_total++;
               r.status = STAT_ADDED;
            end
         end
         CMD_GET: begin
            if (queued_total == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               best = 0;
               for (int i = 1; i < queued_total; i++) begin
                  if (queued_prio[i] > queued_prio[best]) best = i;
               end
               r.job_priority = queued_prio[best];
               for (int i = best; i + 1 < queued_total; i++) begin
                  queued_prio[i] = queued_prio[i + 1];
                  queued_wait[i] = queued_wait[i + 1];
               end
               queued_total--;
               for (int i = 0; i < queued_total; i++) begin
                  if (queued_wait[i] < cfg_threshold) queued_wait[i]++;
                  if (queued_wait[i] >= cfg_threshold) begin
                     sum = {1'b0, queued_prio[i]} + cfg_bonus;
                     queued_prio[i] = (sum > {1'b0, PrioMax}) ? PrioMax : sum[PrioWidth-1:0];
                  end
               end
               r.status = STAT_RETURNED;
            end
         end
         CMD_CLEAR: begin
            queued_total = 0;
            r.status = STAT_CLEARED;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic logic [PrioWidth-1:0] random_job_priority();
      logic [PrioWidth-1:0] p;
      case ($urandom_range(0, 3))
         0:       p = PrioWidth'($urandom_range(1, 6));
         1:       p = PrioMax - PrioWidth'($urandom_range(0, 700));
         default: p = PrioWidth'($urandom_range(0, 65535));
      endcase
      return p;
   endfunction

   function automatic req_word_type random_word(int add_pct);
      req_word_type w;
      int           roll;
      roll = $urandom_range(0, 99);
      w.new_priority = random_job_priority();
      if (roll < add_pct) begin
         w.command = CMD_ADD;
         if ($urandom_range(0, 19) == 0) w.new_priority = '0;
      end else if (roll < 96) begin
         w.command = CMD_GET;
      end else if (roll < 98) begin
         w.command = CMD_CLEAR;
      end else begin
         w.command = CmdUnused;
      end
      return w;
   endfunction

   // Entered and left at a falling edge; valid stays high into the next word.
   task automatic send_word(req_word_type w, logic fixed, rsp_word_type fixed_rsp);
      rsp_word_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = predict_rsp(w);
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_settings(logic [WaitWidth-1:0] threshold,
                                 logic [BonusWidth-1:0] bonus);
      drain_responses();
      csr_valid <= 1'b1;
      csr_index <= CSR_AGE_THRESHOLD;
      csr_data  <= CsrDataWidth'(threshold);
      do @(posedge clock); while (!csr_ready);
      cfg_threshold = threshold;
      @(negedge clock);
      csr_index <= CSR_AGE_BONUS;
      csr_data  <= bonus;
      do @(posedge clock); while (!csr_ready);
      cfg_bonus = bonus;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int idle_pct, int stall_pct, logic [WaitWidth-1:0] threshold,
                             logic [BonusWidth-1:0] bonus, int count, int add_pct);
      write_settings(threshold, bonus);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_word(random_word(add_pct), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(hold_go) begin
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
               $display("Unexpected response word: job_priority %0d status %0d",
                        rsp_word.job_priority, rsp_word.status);
            end
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_word.job_priority !== oldest_rsp.job_priority ||
                rsp_word.status !== oldest_rsp.status) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("Mismatch: expected job_priority %0d status %0d, got %0d status %0d",
                           oldest_rsp.job_priority, oldest_rsp.status,
                           rsp_word.job_priority, rsp_word.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IdleLimit) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      hold_off       = 1'b0;
      mismatch_count = 0;
      idle_cycles    = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      queued_total   = 0;
      cfg_threshold  = ThresholdReset;
      cfg_bonus      = BonusReset;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_word('{directed_rows[i].command, directed_rows[i].new_priority},
                   directed_rows[i].fixed, directed_rows[i].rsp);
      end

      run_random(0,  0,  3'd7, 8'd255, 150, 70);
      run_random(88, 0,  3'd1, 8'd0,   150, 50);
      run_random(0,  88, 3'd0, 8'd200, 150, 62);
      run_random(38, 38, 3'd3, 8'd17,  150, 58);

      // The receiver holds off while words keep coming, so the block backs up.
      write_settings(ThresholdReset, BonusReset);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_go;
      repeat (100) send_word(random_word(75), 1'b0, '0);

      drain_responses();
      repeat (QueueDepth + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
